// ===== hdl/csl_pkg.sv =====
package csl_pkg;

  localparam int MAX_TEXT_DEF = 65536;
  localparam int FIFO_DEPTH   = 4;
  localparam int NUM_KW       = 5;

  localparam logic [2:0] KIND_NUMBER  = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_KEYWORD = 3'd2;
  localparam logic [2:0] KIND_PUNCT   = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  localparam logic [4:0] P_SLASH    = 5'd3;
  localparam logic [4:0] P_LT       = 5'd13;
  localparam logic [4:0] P_GT       = 5'd14;
  localparam logic [4:0] P_BANG     = 5'd15;
  localparam logic [4:0] CODE_EQ_EQ = 5'd17;
  localparam logic [4:0] CODE_NE    = 5'd18;
  localparam logic [4:0] CODE_LE    = 5'd19;
  localparam logic [4:0] CODE_GE    = 5'd20;
  localparam logic [4:0] CODE_NONE  = 5'd0;

  localparam logic [4:0] ERR_INVALID      = 5'd0;
  localparam logic [4:0] ERR_OPEN_COMMENT = 5'd1;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_ZERO  = "0";

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd6, 3'd2, 3'd4, 3'd5};

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  code;
    logic [31:0] value;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } punct_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
  endfunction

  function automatic punct_t punct_lookup(input logic [7:0] c);
    punct_t p;
    p.found = 1'b1;
    case (c)
      "+":     p.idx = 5'd0;
      "-":     p.idx = 5'd1;
      "*":     p.idx = 5'd2;
      "/":     p.idx = 5'd3;
      "(":     p.idx = 5'd4;
      ")":     p.idx = 5'd5;
      "[":     p.idx = 5'd6;
      "]":     p.idx = 5'd7;
      "{":     p.idx = 5'd8;
      "}":     p.idx = 5'd9;
      ";":     p.idx = 5'd10;
      ",":     p.idx = 5'd11;
      "=":     p.idx = 5'd12;
      "<":     p.idx = 5'd13;
      ">":     p.idx = 5'd14;
      "!":     p.idx = 5'd15;
      "&":     p.idx = 5'd16;
      default: begin
        p.found = 1'b0;
        p.idx   = 5'd0;
      end
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/csl_ifs.sv =====
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface csl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [4:0]  token_code;
  logic [31:0] number_value;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_code, output number_value,
                  output start_offset, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_code, input number_value,
                  input start_offset, input token_length, input last_of_run,
                  output ready);
endinterface

// ===== hdl/csl_core.sv =====
module csl_core #(
  parameter int MAX_TEXT = csl_pkg::MAX_TEXT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  output csl_pkg::res_t res0,
  output csl_pkg::res_t res1,
  output logic [1:0]    res_n
);
  import csl_pkg::*;

  localparam int PosW = $clog2(MAX_TEXT);

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_NUMBER     = 8'b0000_0010,
    ST_IDENT      = 8'b0000_0100,
    ST_HELD       = 8'b0000_1000,
    ST_LINE       = 8'b0001_0000,
    ST_BLOCK      = 8'b0010_0000,
    ST_BLOCK_STAR = 8'b0100_0000,
    ST_ERROR      = 8'b1000_0000
  } mode_t;

  mode_t               mode, mode_next;
  logic [31:0]         accum, accum_next;
  logic [NUM_KW-1:0]   cand, cand_next;
  logic [PosW-1:0]     tstart, tstart_next;
  logic [15:0]         tcount, tcount_next;
  logic [4:0]          held, held_next;
  logic [PosW-1:0]     pos, pos_next;
  logic [PosW-1:0]     cstart, cstart_next;

  logic                eot;
  logic [3:0]          digit;
  logic [35:0]         prod;
  logic [31:0]         accum_dig;
  logic [15:0]         tcount_inc;
  logic [NUM_KW-1:0]   cand_upd;
  logic [NUM_KW-1:0]   cand_first;
  punct_t              pu;
  logic                holdable;
  logic                flush_v;
  res_t                flush_r;
  logic                a_v, b_v, do_begin;
  res_t                a_r, b_r;

  assign eot        = end_of_text || (text_byte == 8'h00);
  assign digit      = 4'(text_byte - CH_ZERO);
  assign prod       = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + 36'(digit);
  assign accum_dig  = (prod[35:32] != 4'b0) ? 32'hFFFF_FFFF : prod[31:0];
  assign tcount_inc = (tcount == 16'hFFFF) ? tcount : tcount + 16'd1;
  assign pu         = punct_lookup(text_byte);
  assign holdable   = (text_byte == CH_EQ) || (text_byte == CH_BANG) || (text_byte == CH_LT) ||
                      (text_byte == CH_GT) || (text_byte == CH_SLASH);

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      cand_upd[k]   = cand[k] && (tcount < 16'(KW_LEN[k])) &&
                      (KW_TEXT[k][tcount[2:0]] == text_byte);
      cand_first[k] = (KW_TEXT[k][0] == text_byte);
    end
  end

  always_comb begin
    flush_v = 1'b0;
    flush_r = '0;
    unique case (mode)
      ST_NUMBER: begin
        flush_v        = 1'b1;
        flush_r.kind   = KIND_NUMBER;
        flush_r.value  = accum;
        flush_r.start  = 16'(tstart);
        flush_r.length = tcount;
      end
      ST_IDENT: begin
        flush_v        = 1'b1;
        flush_r.kind   = KIND_IDENT;
        flush_r.start  = 16'(tstart);
        flush_r.length = tcount;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
          if (cand[k] && (tcount == 16'(KW_LEN[k]))) begin
            flush_r.kind = KIND_KEYWORD;
            flush_r.code = 5'(k);
          end
        end
      end
      ST_HELD: begin
        flush_v        = 1'b1;
        flush_r.kind   = KIND_PUNCT;
        flush_r.code   = held;
        flush_r.start  = 16'(tstart);
        flush_r.length = 16'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_next   = mode;
    accum_next  = accum;
    cand_next   = cand;
    tstart_next = tstart;
    tcount_next = tcount;
    held_next   = held;
    pos_next    = pos;
    cstart_next = cstart;
    a_v         = 1'b0;
    b_v         = 1'b0;
    a_r         = '0;
    b_r         = '0;
    do_begin    = 1'b0;

    if (eot) begin
      if (mode == ST_BLOCK || mode == ST_BLOCK_STAR) begin
        a_v       = 1'b1;
        a_r.kind  = KIND_ERROR;
        a_r.code  = ERR_OPEN_COMMENT;
        a_r.start = 16'(cstart);
      end else begin
        a_v = flush_v;
        a_r = flush_r;
      end
      b_v         = 1'b1;
      b_r.kind    = KIND_END;
      b_r.start   = 16'(pos);
      mode_next   = ST_IDLE;
      accum_next  = '0;
      cand_next   = '1;
      tstart_next = '0;
      tcount_next = '0;
      held_next   = '0;
      pos_next    = '0;
      cstart_next = '0;
    end else begin
      unique case (mode)
        ST_ERROR: ;
        ST_LINE: begin
          if (text_byte == CH_LF) mode_next = ST_IDLE;
        end
        ST_BLOCK: begin
          if (text_byte == CH_STAR) mode_next = ST_BLOCK_STAR;
        end
        ST_BLOCK_STAR: begin
          if (text_byte == CH_SLASH) begin
            mode_next = ST_IDLE;
          end else if (text_byte != CH_STAR) begin
            mode_next = ST_BLOCK;
          end
        end
        ST_NUMBER: begin
          if (is_digit(text_byte)) begin
            accum_next  = accum_dig;
            tcount_next = tcount_inc;
          end else begin
            do_begin = 1'b1;
          end
        end
        ST_IDENT: begin
          if (is_alpha(text_byte) || is_digit(text_byte)) begin
            cand_next   = cand_upd;
            tcount_next = tcount_inc;
          end else begin
            do_begin = 1'b1;
          end
        end
        ST_HELD: begin
          if (held == P_SLASH) begin
            if (text_byte == CH_SLASH) begin
              mode_next = ST_LINE;
            end else if (text_byte == CH_STAR) begin
              cstart_next = tstart;
              mode_next   = ST_BLOCK;
            end else begin
              do_begin = 1'b1;
            end
          end else if (text_byte == CH_EQ) begin
            a_v        = 1'b1;
            a_r.kind   = KIND_PUNCT;
            a_r.start  = 16'(tstart);
            a_r.length = 16'd2;
            unique case (held)
              P_BANG:  a_r.code = CODE_NE;
              P_LT:    a_r.code = CODE_LE;
              P_GT:    a_r.code = CODE_GE;
              default: a_r.code = CODE_EQ_EQ;
            endcase
            mode_next = ST_IDLE;
          end else begin
            do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase

      if (do_begin) begin
        a_v       = flush_v;
        a_r       = flush_r;
        mode_next = ST_IDLE;
        if (!is_space(text_byte)) begin
          tstart_next = pos;
          tcount_next = '0;
          if (is_digit(text_byte)) begin
            mode_next   = ST_NUMBER;
            accum_next  = 32'(digit);
            tcount_next = 16'd1;
          end else if (is_alpha(text_byte)) begin
            mode_next   = ST_IDENT;
            cand_next   = cand_first;
            tcount_next = 16'd1;
          end else if (!pu.found) begin
            b_v       = 1'b1;
            b_r.kind  = KIND_ERROR;
            b_r.code  = ERR_INVALID;
            b_r.start = 16'(pos);
            mode_next = ST_ERROR;
          end else if (holdable) begin
            held_next = pu.idx;
            mode_next = ST_HELD;
          end else begin
            b_v        = 1'b1;
            b_r.kind   = KIND_PUNCT;
            b_r.code   = pu.idx;
            b_r.start  = 16'(pos);
            b_r.length = 16'd1;
          end
        end
      end

      pos_next = (pos == PosW'(MAX_TEXT - 1)) ? '0 : pos + 1'b1;
    end

    a_r.last = !b_v;
    b_r.last = 1'b1;
  end

  assign res0  = a_v ? a_r : b_r;
  assign res1  = b_r;
  assign res_n = step ? (2'(a_v) + 2'(b_v)) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= ST_IDLE;
      accum  <= '0;
      cand   <= '1;
      tstart <= '0;
      tcount <= '0;
      held   <= '0;
      pos    <= '0;
      cstart <= '0;
    end else if (step) begin
      mode   <= mode_next;
      accum  <= accum_next;
      cand   <= cand_next;
      tstart <= tstart_next;
      tcount <= tcount_next;
      held   <= held_next;
      pos    <= pos_next;
      cstart <= cstart_next;
    end
  end

endmodule

// ===== hdl/csl_fifo.sv =====
module csl_fifo (
  input  logic          clk,
  input  logic          rst,
  input  csl_pkg::res_t push0,
  input  csl_pkg::res_t push1,
  input  logic [1:0]    push_n,
  output logic          room,
  output logic          valid,
  input  logic          ready,
  output csl_pkg::res_t head
);
  import csl_pkg::*;

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  res_t            slots [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt;
  logic            pop;

  assign valid = (cnt != '0);
  assign pop   = valid && ready;
  assign room  = (cnt <= CntW'(FIFO_DEPTH - 2));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) slots[wr_ptr] <= push0;
    if (push_n == 2'd2) slots[PtrW'(wr_ptr + 1'b1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_n);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + CntW'(push_n) - CntW'(pop);
    end
  end

endmodule

// ===== hdl/c_subset_lexer.sv =====
// Channel  Dir  Payload                                             Transfer
// in_ch    in   text_byte[8], end_of_text[1]                        valid && ready
// out_ch   out  token_kind[3], token_code[5], number_value[32],    valid && ready
//               start_offset[16], token_length[16], last_of_run[1]
//
// One byte per cycle while the queue has room: a byte waits in the input register, is
// lexed from it and its zero, one or two tokens land in a four-entry result queue.
// Tokens are registered in the queue and offered on out_ch from its head, in order.
// The input register advances only while the queue has room for two tokens, so an
// out_ch stall holds in_ch once more than two tokens wait and a byte is registered.
// Synchronous reset empties the queue and returns the scanner to idle at offset 0.
module c_subset_lexer #(
  parameter int MAX_TEXT = csl_pkg::MAX_TEXT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  csl_in_if.sink    in_ch,
  csl_out_if.source out_ch
);
  import csl_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eot;
  logic       room;
  logic       step;
  res_t       res0, res1, head;
  logic [1:0] res_n;

  assign step        = in_full && room;
  assign in_ch.ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte <= in_ch.text_byte;
      in_eot  <= in_ch.end_of_text;
    end
  end

  csl_core #(.MAX_TEXT(MAX_TEXT)) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_byte   (in_byte),
    .end_of_text (in_eot),
    .res0        (res0),
    .res1        (res1),
    .res_n       (res_n)
  );

  csl_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push0  (res0),
    .push1  (res1),
    .push_n (res_n),
    .room   (room),
    .valid  (out_ch.valid),
    .ready  (out_ch.ready),
    .head   (head)
  );

  assign out_ch.token_kind   = head.kind;
  assign out_ch.token_code   = head.code;
  assign out_ch.number_value = head.value;
  assign out_ch.start_offset = head.start;
  assign out_ch.token_length = head.length;
  assign out_ch.last_of_run  = head.last;

endmodule

// ===== hdl/csl_chk.sv =====
module csl_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  token_kind,
  input logic [4:0]  token_code,
  input logic [31:0] number_value,
  input logic [15:0] token_length,
  input logic        last_of_run
);
  import csl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_code) &&
      $stable(number_value) && $stable(token_length) && $stable(last_of_run))
    else $error("out_ch payload changed during stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("lexer not empty and ready after reset");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_END |->
      last_of_run && token_length == 16'd0 && number_value == 32'd0 && token_code == CODE_NONE)
    else $error("malformed end token");

  a_number: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_NUMBER |-> token_length != 16'd0 && token_code == CODE_NONE)
    else $error("malformed number token");

  a_punct: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_PUNCT |->
      token_code <= CODE_GE && (token_length == 16'd1 || token_length == 16'd2))
    else $error("malformed punctuator token");

endmodule

bind c_subset_lexer csl_chk u_csl_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_kind   (out_ch.token_kind),
  .token_code   (out_ch.token_code),
  .number_value (out_ch.number_value),
  .token_length (out_ch.token_length),
  .last_of_run  (out_ch.last_of_run)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csl_pkg::*;

  localparam int LIMIT = 3_000_000;
  localparam int ITEMS_PER_PHASE = 315;
  localparam int HOLD_CYCLES = 300;
  localparam int TX_IDLE [4] = '{0, 78, 0, 8};
  localparam int RX_STALL [4] = '{0, 0, 78, 8};

  localparam logic [7:0] PUNCT_CHARS [17] = '{
    "+", "-", "*", "/", "(", ")", "[", "]", "{", "}", ";", ",", "=", "<", ">", "!", "&"
  };

  typedef enum logic [3:0] {
    S_IDLE, S_NUMBER, S_IDENT, S_HELD, S_LINE, S_BLOCK, S_BLOCK_STAR, S_ERROR
  } scan_e;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dir_row_t;

  logic clk;
  logic rst;

  csl_in_if  in_ch ();
  csl_out_if out_ch ();

  c_subset_lexer u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scan_e       mode;
  logic [31:0] accum;
  logic [4:0]  cands;
  logic [15:0] tstart;
  logic [15:0] tcount;
  logic [4:0]  held;
  int          pos;
  logic [15:0] cstart;
  res_t        step_q [$];

  res_t     expected_tokens [$];
  dir_row_t directed_rows [$];
  logic [1:0] cur_n;
  res_t       cur_r0;
  res_t       cur_r1;

  int mismatches;
  int cycles;
  int sent;
  int tx_idle_pct;
  int rx_stall_pct;
  logic hold_req;
  int hold_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic res_t tok(logic [2:0] kind, logic [4:0] code, logic [31:0] value,
                               logic [15:0] start, logic [15:0] len, logic last);
    res_t r;
    r.kind   = kind;
    r.code   = code;
    r.value  = value;
    r.start  = start;
    r.length = len;
    r.last   = last;
    return r;
  endfunction

  function automatic string keyword_text(int k);
    case (k)
      0: return "int";
      1: return "return";
      2: return "if";
      3: return "else";
      default: return "while";
    endcase
  endfunction

  function automatic logic tok_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic tok_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic tok_alpha(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic int punct_code(logic [7:0] c);
    for (int i = 0; i < 17; i++)
      if (PUNCT_CHARS[i] == c) return i;
    return -1;
  endfunction

  function automatic logic lexable(logic [7:0] c);
    return tok_space(c) || tok_digit(c) || tok_alpha(c) || (punct_code(c) >= 0);
  endfunction

  function automatic void reset_scan();
    mode   = S_IDLE;
    accum  = '0;
    cands  = 5'h1F;
    tstart = '0;
    tcount = '0;
    held   = '0;
    pos    = 0;
    cstart = '0;
  endfunction

  function automatic void add_token(logic [2:0] kind, logic [4:0] code, logic [31:0] value,
                                    logic [15:0] start, logic [15:0] len);
    if (step_q.size() < 2) step_q.push_back(tok(kind, code, value, start, len, 1'b0));
  endfunction

  function automatic void count_char();
    if (tcount != 16'hFFFF) tcount = tcount + 16'd1;
  endfunction

  function automatic void ident_char(logic [7:0] c);
    string kw;
    for (int k = 0; k < 5; k++) begin
      kw = keyword_text(k);
      if (cands[k]) begin
        if (tcount >= kw.len()) cands[k] = 1'b0;
        else if (kw[tcount] != c) cands[k] = 1'b0;
      end
    end
    count_char();
  endfunction

  function automatic void digit_char(logic [7:0] c);
    logic [31:0] d;
    d = 32'(c - "0");
    if (accum > (32'hFFFF_FFFF - d) / 32'd10) accum = 32'hFFFF_FFFF;
    else accum = accum * 32'd10 + d;
    count_char();
  endfunction

  function automatic void flush_pending();
    logic found;
    string kw;
    found = 1'b0;
    case (mode)
      S_NUMBER: add_token(KIND_NUMBER, CODE_NONE, accum, tstart, tcount);
      S_IDENT: begin
        for (int k = 0; k < 5; k++) begin
          kw = keyword_text(k);
          if (!found && cands[k] && kw.len() == tcount) begin
            add_token(KIND_KEYWORD, 5'(k), '0, tstart, tcount);
            found = 1'b1;
          end
        end
        if (!found) add_token(KIND_IDENT, CODE_NONE, '0, tstart, tcount);
      end
      S_HELD: add_token(KIND_PUNCT, held, '0, tstart, 16'd1);
      default: ;
    endcase
  endfunction

  function automatic void start_token(logic [7:0] c);
    int p;
    mode = S_IDLE;
    if (tok_space(c)) return;
    tstart = 16'(pos);
    tcount = '0;
    if (tok_digit(c)) begin
      mode  = S_NUMBER;
      accum = '0;
      digit_char(c);
      return;
    end
    if (tok_alpha(c)) begin
      mode  = S_IDENT;
      cands = 5'h1F;
      ident_char(c);
      return;
    end
    p = punct_code(c);
    if (p < 0) begin
      add_token(KIND_ERROR, ERR_INVALID, '0, 16'(pos), '0);
      mode = S_ERROR;
    end else if (c inside {CH_EQ, CH_BANG, CH_LT, CH_GT, CH_SLASH}) begin
      held = 5'(p);
      mode = S_HELD;
    end else begin
      add_token(KIND_PUNCT, 5'(p), '0, 16'(pos), 16'd1);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b, logic eot);
    logic [4:0] pair;
    res_t r;
    step_q.delete();
    if (eot || b == 8'h00) begin
      if (mode inside {S_BLOCK, S_BLOCK_STAR})
        add_token(KIND_ERROR, ERR_OPEN_COMMENT, '0, cstart, '0);
      else
        flush_pending();
      add_token(KIND_END, CODE_NONE, '0, 16'(pos), '0);
      reset_scan();
    end else begin
      case (mode)
        S_ERROR: ;
        S_LINE: if (b == CH_LF) mode = S_IDLE;
        S_BLOCK: if (b == CH_STAR) mode = S_BLOCK_STAR;
        S_BLOCK_STAR: begin
          if (b == CH_SLASH) mode = S_IDLE;
          else if (b != CH_STAR) mode = S_BLOCK;
        end
        S_NUMBER: begin
          if (tok_digit(b)) begin
            digit_char(b);
          end else begin
            flush_pending();
            start_token(b);
          end
        end
        S_IDENT: begin
          if (tok_alpha(b) || tok_digit(b)) begin
            ident_char(b);
          end else begin
            flush_pending();
            start_token(b);
          end
        end
        S_HELD: begin
          if (held == P_SLASH) begin
            if (b == CH_SLASH) begin
              mode = S_LINE;
            end else if (b == CH_STAR) begin
              cstart = tstart;
              mode   = S_BLOCK;
            end else begin
              flush_pending();
              start_token(b);
            end
          end else if (b == CH_EQ) begin
            pair = (held == P_BANG) ? CODE_NE :
                   (held == P_LT)   ? CODE_LE :
                   (held == P_GT)   ? CODE_GE : CODE_EQ_EQ;
            add_token(KIND_PUNCT, pair, '0, tstart, 16'd2);
            mode = S_IDLE;
          end else begin
            flush_pending();
            start_token(b);
          end
        end
        default: start_token(b);
      endcase
      pos = (pos + 1 >= MAX_TEXT_DEF) ? 0 : pos + 1;
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        lex_byte(in_ch.text_byte, in_ch.end_of_text);
        if (cur_n == 2'd0) begin
          foreach (step_q[i]) expected_tokens.push_back(step_q[i]);
        end else begin
          expected_tokens.push_back(cur_r0);
          if (cur_n == 2'd2) expected_tokens.push_back(cur_r1);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = tok(out_ch.token_kind, out_ch.token_code, out_ch.number_value,
                  out_ch.start_offset, out_ch.token_length, out_ch.last_of_run);
        if (expected_tokens.size() == 0) begin
          flag_mismatch($sformatf("unexpected token kind %0d code %0d start %0d",
                                  got.kind, got.code, got.start));
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind)
            flag_mismatch($sformatf("token_kind %0d, want %0d", got.kind, want.kind));
          if (got.code !== want.code)
            flag_mismatch($sformatf("token_code %0d, want %0d", got.code, want.code));
          if (got.value !== want.value)
            flag_mismatch($sformatf("number_value %0d, want %0d", got.value, want.value));
          if (got.start !== want.start)
            flag_mismatch($sformatf("start_offset %0d, want %0d", got.start, want.start));
          if (got.length !== want.length)
            flag_mismatch($sformatf("token_length %0d, want %0d", got.length, want.length));
          if (got.last !== want.last)
            flag_mismatch($sformatf("last_of_run %0d, want %0d", got.last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_req     = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eot, input logic [1:0] n = 2'd0,
                           input res_t r0 = '0, input res_t r1 = '0);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid     = 1'b0;
      in_ch.text_byte = 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.text_byte   = b;
    in_ch.end_of_text = eot;
    cur_n  = n;
    cur_r0 = r0;
    cur_r1 = r1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic dir_row(logic [7:0] b, logic eot, logic [1:0] n = 2'd0,
                         res_t r0 = '0, res_t r1 = '0);
    dir_row_t row;
    row.b   = b;
    row.eot = eot;
    row.n   = n;
    row.r0  = r0;
    row.r1  = r1;
    directed_rows.push_back(row);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      default: return 8'($urandom_range(9, 13));
    endcase
  endfunction

  task automatic random_text();
    logic [7:0] txt [$];
    logic [7:0] c;
    logic noisy;
    int ntok, pick, len, counted;
    string kw;
    noisy = 1'b0;
    ntok  = $urandom_range(1, 24);
    for (int t = 0; t < ntok && !noisy; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        repeat (len) txt.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 42) begin
        kw = keyword_text($urandom_range(0, 4));
        case ($urandom_range(0, 3))
          0, 1: for (int i = 0; i < kw.len(); i++) txt.push_back(kw[i]);
          2: begin
            len = $urandom_range(1, kw.len());
            for (int i = 0; i < len; i++) txt.push_back(kw[i]);
          end
          default: begin
            do c = rand_alnum(); while (tok_digit(c));
            txt.push_back(c);
            repeat ($urandom_range(0, 7)) txt.push_back(rand_alnum());
          end
        endcase
        if ($urandom_range(0, 5) == 0) txt.push_back(rand_alnum());
      end else if (pick < 62) begin
        case ($urandom_range(0, 2))
          0: txt.push_back(PUNCT_CHARS[$urandom_range(0, 16)]);
          1: begin
            case ($urandom_range(0, 3))
              0: txt.push_back(CH_EQ);
              1: txt.push_back(CH_BANG);
              2: txt.push_back(CH_LT);
              default: txt.push_back(CH_GT);
            endcase
            txt.push_back(CH_EQ);
          end
          default: begin
            txt.push_back(PUNCT_CHARS[$urandom_range(0, 16)]);
            txt.push_back(PUNCT_CHARS[$urandom_range(0, 16)]);
          end
        endcase
      end else if (pick < 70) begin
        txt.push_back(CH_SLASH);
        txt.push_back(CH_SLASH);
        repeat ($urandom_range(0, 10)) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_LF);
          txt.push_back(c);
        end
        txt.push_back(CH_LF);
      end else if (pick < 78) begin
        txt.push_back(CH_SLASH);
        txt.push_back(CH_STAR);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 4))
            0: txt.push_back(CH_STAR);
            1: txt.push_back(CH_SLASH);
            2: txt.push_back(rand_alnum());
            3: txt.push_back(rand_space());
            default: txt.push_back(8'($urandom_range(1, 255)));
          endcase
        end
        txt.push_back(CH_STAR);
        txt.push_back(CH_SLASH);
      end else if (pick < 97) begin
        txt.push_back(rand_space());
      end else begin
        do c = 8'($urandom_range(1, 255)); while (lexable(c));
        txt.push_back(c);
        noisy = 1'b1;
      end
      if (!noisy && $urandom_range(0, 1) == 0) txt.push_back(rand_space());
    end
    counted = txt.size();
    if (noisy) begin
      repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(1, 255)));
    end else if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          txt.push_back(CH_SLASH);
          txt.push_back(CH_STAR);
          txt.push_back(rand_alnum());
        end
        1: txt.push_back(CH_SLASH);
        default: txt.push_back(CH_LT);
      endcase
      counted = txt.size();
    end
    foreach (txt[i]) send_item(txt[i], 1'b0);
    if ($urandom_range(0, 2) == 0) send_item(8'h00, 1'b0);
    else send_item(8'($urandom_range(0, 255)), 1'b1);
    sent += counted + 1;
  endtask

  initial begin
    int target;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    cur_n             = '0;
    cur_r0            = '0;
    cur_r1            = '0;
    mismatches        = 0;
    cycles            = 0;
    sent              = 0;
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    reset_scan();

    dir_row(8'hFF, 1'b1, 2'd1, tok(KIND_END, CODE_NONE, '0, 16'd0, '0, 1'b1));
    dir_row(8'hFF, 1'b0, 2'd1, tok(KIND_ERROR, ERR_INVALID, '0, 16'd0, '0, 1'b1));
    dir_row("a", 1'b0);
    dir_row(8'h00, 1'b0, 2'd1, tok(KIND_END, CODE_NONE, '0, 16'd2, '0, 1'b1));
    repeat (11) dir_row("9", 1'b0);
    dir_row(" ", 1'b0, 2'd1, tok(KIND_NUMBER, CODE_NONE, 32'hFFFF_FFFF, 16'd0, 16'd11, 1'b1));
    dir_row("/", 1'b0);
    dir_row("*", 1'b0);
    dir_row("/", 1'b0);
    dir_row(8'h00, 1'b1, 2'd2, tok(KIND_ERROR, ERR_OPEN_COMMENT, '0, 16'd12, '0, 1'b0),
            tok(KIND_END, CODE_NONE, '0, 16'd15, '0, 1'b1));
    dir_row("<", 1'b0);
    dir_row("=", 1'b0, 2'd1, tok(KIND_PUNCT, CODE_LE, '0, 16'd0, 16'd2, 1'b1));
    dir_row("i", 1'b0);
    dir_row("f", 1'b0);
    dir_row("(", 1'b0);
    dir_row("!", 1'b0);
    dir_row("x", 1'b0);
    dir_row("9", 1'b0);
    dir_row(">", 1'b0);
    dir_row(8'h7F, 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].b, directed_rows[i].eot, directed_rows[i].n,
                directed_rows[i].r0, directed_rows[i].r1);
    while (expected_tokens.size() != 0) @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = TX_IDLE[ph];
      rx_stall_pct = RX_STALL[ph];
      if (ph == 0) begin
        // long identifier
        send_item("a", 1'b0);
        repeat (199) send_item(rand_alnum(), 1'b0);
        send_item(" ", 1'b0);
        send_item("x", 1'b0);
        send_item(8'h00, 1'b0);
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      target = sent + ITEMS_PER_PHASE;
      while (sent < target) random_text();
      while (expected_tokens.size() != 0) @(negedge clk);
    end

    repeat (20) @(negedge clk);
    if (expected_tokens.size() != 0)
      flag_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
